### sv/soc_pkg.sv
// Package with shared constants, verdict codes and lane/merge types of the subslot classifier.
package soc_pkg;

    localparam int SCAN_BYTES = 6;
    localparam int SUBSLOTS   = 48;
    localparam int LANES      = 8;
    localparam int COUNT_W    = 7;
    localparam int POS_W      = 3;
    localparam int INC_W      = $clog2(LANES + 1);
    localparam int PCT_W      = 7;
    localparam int PCT_MAX    = 100;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 80;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'((SCAN_BYTES - 1) % 8);

    // Percentage by reciprocal: floor(sum * 100 / SUBSLOTS) = (sum * PCT_RECIP) >> PCT_SHIFT.
    localparam int SUM_W       = COUNT_W + 1;
    localparam int PCT_SHIFT   = SUM_W + $clog2(SUBSLOTS) + 1;
    localparam longint PCT_RECIP =
        (longint'(PCT_MAX) * (longint'(1) << PCT_SHIFT) + SUBSLOTS - 1) / SUBSLOTS;
    localparam int PCT_RECIP_W = $clog2(PCT_RECIP + 1);
    localparam int PROD_W      = SUM_W + PCT_RECIP_W;

    typedef enum logic [1:0] {
        V_UNKNOWN  = 2'd0,
        V_FREE     = 2'd1,
        V_POSSIBLE = 2'd2,
        V_BUSY     = 2'd3
    } verdict_t;

    typedef struct packed {
        logic     marked;
        verdict_t verdict;
    } lane_result_t;

    typedef struct packed {
        logic [2*LANES-1:0] verdicts;
        verdict_t           last_verdict;
        logic [INC_W-1:0]   free_inc;
        logic [INC_W-1:0]   possible_inc;
        logic [INC_W-1:0]   busy_inc;
        logic               unmarked;
    } merge_result_t;

endpackage

### sv/soc_lane.sv
// One subslot lane: priority classification of a single subslot.
module soc_lane
    import soc_pkg::*;
(
    input  logic         busy_bit,
    input  logic         possible_bit,
    input  logic         free_bit,
    output lane_result_t result
);

    always_comb
    begin
        result.marked = busy_bit | possible_bit | free_bit;
        if (busy_bit)
        begin
            result.verdict = V_BUSY;
        end
        else if (possible_bit)
        begin
            result.verdict = V_POSSIBLE;
        end
        else if (free_bit)
        begin
            result.verdict = V_FREE;
        end
        else
        begin
            result.verdict = V_UNKNOWN;
        end
    end

endmodule

### sv/soc_merge.sv
// Merge: carries verdicts into unmarked subslots and counts free, possible and busy lanes.
module soc_merge
    import soc_pkg::*;
(
    input  lane_result_t  lanes [LANES],
    input  verdict_t      prev_verdict,
    output merge_result_t merged
);

    always_comb
    begin
        verdict_t carry;
        carry = prev_verdict;
        merged.free_inc     = '0;
        merged.possible_inc = '0;
        merged.busy_inc     = '0;
        merged.unmarked     = 1'b0;
        merged.verdicts     = '0;
        for (int j = 0; j < LANES; j++)
        begin
            if (lanes[j].marked)
            begin
                carry = lanes[j].verdict;
            end
            else
            begin
                merged.unmarked = 1'b1;
            end
            merged.verdicts[2*j +: 2] = carry;
            case (lanes[j].verdict)
                V_FREE:     merged.free_inc     = merged.free_inc + INC_W'(1);
                V_POSSIBLE: merged.possible_inc = merged.possible_inc + INC_W'(1);
                V_BUSY:     merged.busy_inc     = merged.busy_inc + INC_W'(1);
                default:    ;
            endcase
        end
        merged.last_verdict = carry;
    end

endmodule

### sv/subslot_occupancy_classifier.sv
// Top level of the subslot occupancy classifier: lanes, merge, scan state and output pipeline.
// An accepted item passes the first-stage and output registers before it shows on m_tvalid.
// Throughput: one item per cycle unless the output stalls; the eight lanes and the merge
// are combinational. The second stage computes the percentage and registers the output
// item; a stalled output holds both stages.
// Reset (rst_n low, asynchronous) empties the pipeline and returns the scan state to the
// start of a scan: position 0, zero counts, all-free set, previous verdict unknown.
module subslot_occupancy_classifier
    import soc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // busy_bits[7:0], possible_bits[15:8], free_bits[23:16], channel[39:24],
    // busy_level[46:40], zero fill[47]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // subslot_verdicts[15:0], first_subslot[21:16], free_total[28:22],
    // possible_total[35:29], busy_total[42:36], suitable_percent[49:43], all_free[50],
    // channel_out[66:51], busy_level_out[73:67], unmarked_seen[74], zero fill[79:75]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic [LANES-1:0] busy_bits;
    logic [LANES-1:0] possible_bits;
    logic [LANES-1:0] free_bits;
    logic [15:0]      channel;
    logic [6:0]       busy_level;

    assign busy_bits     = s_tdata[7:0];
    assign possible_bits = s_tdata[15:8];
    assign free_bits     = s_tdata[23:16];
    assign channel       = s_tdata[39:24];
    assign busy_level    = s_tdata[46:40];

    lane_result_t  lane_res [LANES];
    merge_result_t merged;

    // Scan state.
    logic [POS_W-1:0]   pos_reg;
    logic [COUNT_W-1:0] free_cnt_reg;
    logic [COUNT_W-1:0] poss_cnt_reg;
    logic [COUNT_W-1:0] busy_cnt_reg;
    logic               all_free_reg;
    verdict_t           prev_verdict_reg;
    logic               unmarked_reg;

    logic [COUNT_W-1:0] free_cnt_next;
    logic [COUNT_W-1:0] poss_cnt_next;
    logic [COUNT_W-1:0] busy_cnt_next;
    logic               all_free_next;
    logic               unmarked_next;
    logic               done;

    // First stage registers.
    logic               s1_valid_reg;
    logic [2*LANES-1:0] s1_verdicts_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic               s1_done_reg;
    logic [COUNT_W-1:0] s1_free_reg;
    logic [COUNT_W-1:0] s1_poss_reg;
    logic [COUNT_W-1:0] s1_busy_reg;
    logic               s1_all_free_reg;
    logic [15:0]        s1_channel_reg;
    logic [6:0]         s1_level_reg;
    logic               s1_unmarked_reg;

    // Output registers.
    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic               out_last_reg;

    logic               accept;
    logic               out_advance;
    logic               s1_advance;

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            soc_lane u_lane
            (
                .busy_bit     (busy_bits[g]),
                .possible_bit (possible_bits[g]),
                .free_bit     (free_bits[g]),
                .result       (lane_res[g])
            );
        end
    endgenerate

    soc_merge u_merge
    (
        .lanes        (lane_res),
        .prev_verdict (prev_verdict_reg),
        .merged       (merged)
    );

    assign out_advance = !out_valid_reg || m_tready;
    assign s1_advance  = out_advance;
    assign s_tready    = !s1_valid_reg || s1_advance;
    assign accept      = s_tvalid && s_tready;

    assign free_cnt_next = free_cnt_reg + COUNT_W'(merged.free_inc);
    assign poss_cnt_next = poss_cnt_reg + COUNT_W'(merged.possible_inc);
    assign busy_cnt_next = busy_cnt_reg + COUNT_W'(merged.busy_inc);
    assign all_free_next = all_free_reg && (free_bits == '1);
    assign unmarked_next = unmarked_reg || merged.unmarked;
    assign done          = (pos_reg == LAST_POS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            free_cnt_reg     <= '0;
            poss_cnt_reg     <= '0;
            busy_cnt_reg     <= '0;
            all_free_reg     <= 1'b1;
            prev_verdict_reg <= V_UNKNOWN;
            unmarked_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (done)
            begin
                pos_reg          <= '0;
                free_cnt_reg     <= '0;
                poss_cnt_reg     <= '0;
                busy_cnt_reg     <= '0;
                all_free_reg     <= 1'b1;
                prev_verdict_reg <= V_UNKNOWN;
                unmarked_reg     <= 1'b0;
            end
            else
            begin
                pos_reg          <= pos_reg + POS_W'(1);
                free_cnt_reg     <= free_cnt_next;
                poss_cnt_reg     <= poss_cnt_next;
                busy_cnt_reg     <= busy_cnt_next;
                all_free_reg     <= all_free_next;
                prev_verdict_reg <= merged.last_verdict;
                unmarked_reg     <= unmarked_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_verdicts_reg <= merged.verdicts;
            s1_pos_reg      <= pos_reg;
            s1_done_reg     <= done;
            s1_free_reg     <= free_cnt_next;
            s1_poss_reg     <= poss_cnt_next;
            s1_busy_reg     <= busy_cnt_next;
            s1_all_free_reg <= all_free_next;
            s1_channel_reg  <= channel;
            s1_level_reg    <= busy_level;
            s1_unmarked_reg <= unmarked_next;
        end
    end

    // Second stage: percentage by reciprocal multiply, summary fields zero unless done.
    logic [SUM_W-1:0]  suit_sum;
    logic [PROD_W-1:0] pct_prod;
    logic [PROD_W-1:0] pct_quot;
    logic [PCT_W-1:0]  pct;
    logic [M_TDATA_W-1:0] out_data_next;

    assign suit_sum = SUM_W'(s1_free_reg) + SUM_W'(s1_poss_reg);
    assign pct_prod = PROD_W'(suit_sum) * PROD_W'(PCT_RECIP);
    assign pct_quot = pct_prod >> PCT_SHIFT;
    assign pct      = (pct_quot > PROD_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct_quot[PCT_W-1:0];

    always_comb
    begin
        out_data_next         = '0;
        out_data_next[15:0]   = s1_verdicts_reg;
        out_data_next[21:16]  = {s1_pos_reg, 3'b000};
        out_data_next[74]     = s1_unmarked_reg;
        if (s1_done_reg)
        begin
            out_data_next[28:22] = s1_free_reg;
            out_data_next[35:29] = s1_poss_reg;
            out_data_next[42:36] = s1_busy_reg;
            out_data_next[49:43] = pct;
            out_data_next[50]    = s1_all_free_reg;
            out_data_next[66:51] = s1_channel_reg;
            out_data_next[73:67] = s1_level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= s1_done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[73:22] == '0))
        else $error("Summary fields set on an item that does not end the scan.");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[49:43] <= PCT_W'(PCT_MAX)))
        else $error("Suitable percentage above its maximum.");

    a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (pos_reg == '0 && prev_verdict_reg == V_UNKNOWN && all_free_reg))
        else $error("Scan state not restarted after the last byte.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !s1_valid_reg) |-> s_tready)
        else $error("Input stalled while the pipeline is empty.");

endmodule
